/* sv/swcrc_pkg.sv */
// ----------------------------------------------------------------------------
// swcrc_pkg
// Shared types, codes and constant tables of the stop-and-wait CRC-8 receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package swcrc_pkg;

    localparam int HDR_LEN      = 5;
    localparam int END_MARK_LEN = 6;
    localparam int ERR_MARK_LEN = 36;

    localparam logic [15:0] POS_MAX    = 16'hFFFF;
    localparam logic [2:0]  RETRY_INIT = 3'd3;
    localparam logic [2:0]  FAIL_MAX   = 3'd7;

    // Result packing on m_tdata
    localparam int OUT_BYTE_LSB = 0;
    localparam int OUT_VERD_LSB = 8;
    localparam int OUT_SEQ_LSB  = 11;
    localparam int OUT_TDATA_W  = 32;

    typedef enum logic [2:0] {
        VERDICT_NONE    = 3'd0,
        VERDICT_ACK     = 3'd1,
        VERDICT_NACK    = 3'd2,
        VERDICT_ABORT   = 3'd3,
        VERDICT_EOT     = 3'd4,
        VERDICT_ERROR   = 3'd5,
        VERDICT_IGNORED = 3'd6
    } verdict_t;

    typedef enum logic {
        KIND_BYTE  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    // Item as queued between front and back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       eod;
    } q_item_t;

    // Result as held in the output register
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        verdict_t    verdict;
        logic [15:0] expected_seq;
    } result_t;

    localparam logic [7:0] END_MARK [END_MARK_LEN] = '{"E", "O", "F", 8'h09, 8'h09, 8'h09};

    localparam logic [7:0] ERR_MARK [ERR_MARK_LEN] = '{
        "U", "N", "A", "B", "L", "E", "_", "T", "O", "_", "C", "O",
        "M", "P", "L", "E", "T", "E", "_", "T", "H", "E", "_", "O",
        "P", "E", "R", "A", "T", "I", "O", "N", 8'h09, 8'h09, 8'h09, 8'h0A
    };

    // Reflected CRC-8, polynomial 0x4D, table form
    localparam logic [7:0] CRC_TAB [256] = '{
        8'hea, 8'hd4, 8'h96, 8'ha8, 8'h12, 8'h2c, 8'h6e, 8'h50,
        8'h7f, 8'h41, 8'h03, 8'h3d, 8'h87, 8'hb9, 8'hfb, 8'hc5,
        8'ha5, 8'h9b, 8'hd9, 8'he7, 8'h5d, 8'h63, 8'h21, 8'h1f,
        8'h30, 8'h0e, 8'h4c, 8'h72, 8'hc8, 8'hf6, 8'hb4, 8'h8a,
        8'h74, 8'h4a, 8'h08, 8'h36, 8'h8c, 8'hb2, 8'hf0, 8'hce,
        8'he1, 8'hdf, 8'h9d, 8'ha3, 8'h19, 8'h27, 8'h65, 8'h5b,
        8'h3b, 8'h05, 8'h47, 8'h79, 8'hc3, 8'hfd, 8'hbf, 8'h81,
        8'hae, 8'h90, 8'hd2, 8'hec, 8'h56, 8'h68, 8'h2a, 8'h14,
        8'hb3, 8'h8d, 8'hcf, 8'hf1, 8'h4b, 8'h75, 8'h37, 8'h09,
        8'h26, 8'h18, 8'h5a, 8'h64, 8'hde, 8'he0, 8'ha2, 8'h9c,
        8'hfc, 8'hc2, 8'h80, 8'hbe, 8'h04, 8'h3a, 8'h78, 8'h46,
        8'h69, 8'h57, 8'h15, 8'h2b, 8'h91, 8'haf, 8'hed, 8'hd3,
        8'h2d, 8'h13, 8'h51, 8'h6f, 8'hd5, 8'heb, 8'ha9, 8'h97,
        8'hb8, 8'h86, 8'hc4, 8'hfa, 8'h40, 8'h7e, 8'h3c, 8'h02,
        8'h62, 8'h5c, 8'h1e, 8'h20, 8'h9a, 8'ha4, 8'he6, 8'hd8,
        8'hf7, 8'hc9, 8'h8b, 8'hb5, 8'h0f, 8'h31, 8'h73, 8'h4d,
        8'h58, 8'h66, 8'h24, 8'h1a, 8'ha0, 8'h9e, 8'hdc, 8'he2,
        8'hcd, 8'hf3, 8'hb1, 8'h8f, 8'h35, 8'h0b, 8'h49, 8'h77,
        8'h17, 8'h29, 8'h6b, 8'h55, 8'hef, 8'hd1, 8'h93, 8'had,
        8'h82, 8'hbc, 8'hfe, 8'hc0, 8'h7a, 8'h44, 8'h06, 8'h38,
        8'hc6, 8'hf8, 8'hba, 8'h84, 8'h3e, 8'h00, 8'h42, 8'h7c,
        8'h53, 8'h6d, 8'h2f, 8'h11, 8'hab, 8'h95, 8'hd7, 8'he9,
        8'h89, 8'hb7, 8'hf5, 8'hcb, 8'h71, 8'h4f, 8'h0d, 8'h33,
        8'h1c, 8'h22, 8'h60, 8'h5e, 8'he4, 8'hda, 8'h98, 8'ha6,
        8'h01, 8'h3f, 8'h7d, 8'h43, 8'hf9, 8'hc7, 8'h85, 8'hbb,
        8'h94, 8'haa, 8'he8, 8'hd6, 8'h6c, 8'h52, 8'h10, 8'h2e,
        8'h4e, 8'h70, 8'h32, 8'h0c, 8'hb6, 8'h88, 8'hca, 8'hf4,
        8'hdb, 8'he5, 8'ha7, 8'h99, 8'h23, 8'h1d, 8'h5f, 8'h61,
        8'h9f, 8'ha1, 8'he3, 8'hdd, 8'h67, 8'h59, 8'h1b, 8'h25,
        8'h0a, 8'h34, 8'h76, 8'h48, 8'hf2, 8'hcc, 8'h8e, 8'hb0,
        8'hd0, 8'hee, 8'hac, 8'h92, 8'h28, 8'h16, 8'h54, 8'h6a,
        8'h45, 8'h7b, 8'h39, 8'h07, 8'hbd, 8'h83, 8'hc1, 8'hff
    };

endpackage

`default_nettype wire

/* sv/swcrc_front.sv */
// ----------------------------------------------------------------------------
// swcrc_front
// Input side: takes stream transfers, tags start commands, queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module swcrc_front import swcrc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       s_tlast,
    output logic            q_valid,
    output q_item_t         q_item,
    input  wire logic       q_pop
);

    q_item_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    q_item_t    in_item;

    // ready comes straight from a register: queue not full
    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb begin
        in_item.kind      = s_tuser ? KIND_START : KIND_BYTE;
        in_item.data_byte = s_tdata;
        in_item.eod       = s_tlast;
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* sv/swcrc_back.sv */
// ----------------------------------------------------------------------------
// swcrc_back
// Execution side: header parse, chained CRC, verdicts, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swcrc_back import swcrc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  wire q_item_t    q_item,
    output logic            q_pop,
    input  wire logic       cfg_valid,
    input  wire logic [2:0] cfg_data,
    output logic            out_valid,
    output result_t         out_result,
    input  wire logic       out_ready
);

    logic [2:0]  retry_limit_reg;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] fseq_reg, fseq_next;
    logic [7:0]  fcrc_reg, fcrc_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] nseq_reg, nseq_next;
    logic [2:0]  fail_reg, fail_next;
    logic [1:0]  mark_reg, mark_next;
    logic        done_reg, done_next;
    logic        out_valid_reg;
    result_t     out_reg, out_next;

    logic [15:0] pos_capped;
    logic [15:0] len_check;
    logic        complete;
    logic [7:0]  b;
    logic [2:0]  fail_inc;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign b          = q_item.data_byte;

    always_comb begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        fseq_next = fseq_reg;
        fcrc_next = fcrc_reg;
        crc_next  = crc_reg;
        nseq_next = nseq_reg;
        fail_next = fail_reg;
        mark_next = mark_reg;
        done_next = done_reg;
        out_next.payload_valid = 1'b0;
        out_next.payload_byte  = 8'h00;
        out_next.verdict       = VERDICT_NONE;
        pos_capped = (pos_reg < POS_MAX) ? pos_reg : (POS_MAX - 16'd1);
        len_check  = pos_capped - 16'(HDR_LEN - 1);
        complete   = 1'b0;
        fail_inc   = (fail_reg < FAIL_MAX) ? (fail_reg + 3'd1) : fail_reg;

        if (q_item.kind == KIND_START) begin
            pos_next  = 16'd0;
            crc_next  = 8'h00;
            nseq_next = 16'd0;
            fail_next = 3'd0;
            mark_next = 2'b11;
            done_next = 1'b0;
        end else if (done_reg) begin
            out_next.verdict = VERDICT_IGNORED;
        end else begin
            // marker tracking
            if (pos_reg < 16'(END_MARK_LEN) && b != END_MARK[pos_reg[2:0]]) begin
                mark_next[0] = 1'b0;
            end
            if (pos_reg < 16'(ERR_MARK_LEN) && b != ERR_MARK[pos_reg[5:0]]) begin
                mark_next[1] = 1'b0;
            end
            // header fields, then payload
            case (pos_reg)
                16'd0: len_next  = {len_reg[15:8], b};
                16'd1: len_next  = {b, len_reg[7:0]};
                16'd2: fseq_next = {fseq_reg[15:8], b};
                16'd3: fseq_next = {b, fseq_reg[7:0]};
                16'd4: fcrc_next = b;
                default: begin
                    if (pos_reg < POS_MAX && (pos_reg - 16'(HDR_LEN)) < len_reg) begin
                        out_next.payload_valid = 1'b1;
                        out_next.payload_byte  = b;
                        crc_next = CRC_TAB[crc_reg ^ b];
                    end
                end
            endcase

            complete = (pos_reg >= 16'(HDR_LEN - 1)) && (len_check >= len_next);

            if (q_item.eod) begin
                if (mark_next[0] && pos_reg >= 16'(END_MARK_LEN - 1)) begin
                    out_next.verdict = VERDICT_EOT;
                    done_next        = 1'b1;
                end else if (mark_next[1] && pos_reg >= 16'(ERR_MARK_LEN - 1)) begin
                    out_next.verdict = VERDICT_ERROR;
                    done_next        = 1'b1;
                end else if (complete && crc_next == fcrc_next && fseq_next == nseq_reg) begin
                    out_next.verdict = VERDICT_ACK;
                    fail_next        = 3'd0;
                    nseq_next        = nseq_reg + 16'd1;
                end else begin
                    fail_next = fail_inc;
                    if (fail_inc >= retry_limit_reg) begin
                        out_next.verdict = VERDICT_ABORT;
                        done_next        = 1'b1;
                    end else begin
                        out_next.verdict = VERDICT_NACK;
                    end
                end
                pos_next  = 16'd0;
                mark_next = 2'b11;
            end else if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 16'd1;
            end
        end
        out_next.expected_seq = nseq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= RETRY_INIT;
            pos_reg         <= 16'd0;
            len_reg         <= 16'd0;
            fseq_reg        <= 16'd0;
            fcrc_reg        <= 8'h00;
            crc_reg         <= 8'h00;
            nseq_reg        <= 16'd0;
            fail_reg        <= 3'd0;
            mark_reg        <= 2'b11;
            done_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                retry_limit_reg <= cfg_data;
            end
            if (q_pop) begin
                pos_reg  <= pos_next;
                len_reg  <= len_next;
                fseq_reg <= fseq_next;
                fcrc_reg <= fcrc_next;
                crc_reg  <= crc_next;
                nseq_reg <= nseq_next;
                fail_reg <= fail_next;
                mark_reg <= mark_next;
                done_reg <= done_next;
            end
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

/* sv/stop_wait_crc_frame_receiver.sv */
// ----------------------------------------------------------------------------
// stop_wait_crc_frame_receiver
// Stop-and-wait datagram receiver with a chained reflected CRC-8 check.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake             content
//  s_        in   s_tvalid / s_tready   datagram byte, start command, end mark
//  m_        out  m_tvalid / m_tready   payload byte, verdict, expected seq
//  cfg_      in   cfg_valid / cfg_ready retry_limit (3 bits)
//
// One result per input transfer, one transfer per cycle sustained while the
// result side is not stalled. Path from s_ transfer to m_tvalid: a two-entry
// queue in the front part, then the back part's step (one CRC table lookup
// plus the length and sequence compares) into the output register.
// s_tready depends only on the queue fill, m_tready only on the output
// register, so a stall on one side reaches the other after the queue fills.
// Synchronous active-low reset; no clearing pass, ready the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stop_wait_crc_frame_receiver import swcrc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] cmd (1 = start new transfer)
    input  wire logic        s_tlast,   // end_of_datagram
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] payload_byte, [10:8] verdict,
                                        // [26:11] expected_seq, [31:27] zero
    output logic             m_tuser,   // [0] payload_valid
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data   // retry_limit
);

    q_item_t q_item;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    // register write always accepted
    assign cfg_ready = 1'b1;

    swcrc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    swcrc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_result (res),
        .out_ready  (m_tready)
    );

    // pack result, first field lowest
    assign m_tuser = res.payload_valid;
    assign m_tdata = {5'b00000, res.expected_seq, res.verdict, res.payload_byte};

endmodule

`default_nettype wire

/* sv/swcrc_checker.sv */
// ----------------------------------------------------------------------------
// swcrc_checker
// Port-level checks of the receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swcrc_checker import swcrc_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    logic [2:0] verd;
    assign verd = m_tdata[OUT_VERD_LSB +: 3];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // byte field is zero unless it carries payload
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[OUT_BYTE_LSB +: 8] == 8'h00)
        else $error("non-payload result carries a byte");

    // bytes after the end of a transfer never pass as payload
    a_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && verd == VERDICT_IGNORED |-> !m_tuser)
        else $error("ignored byte passed as payload");

    // no verdict code beyond the defined set; padding bits stay zero
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> verd != 3'd7 && m_tdata[31:27] == 5'd0)
        else $error("bad verdict code or padding");

endmodule

bind stop_wait_crc_frame_receiver swcrc_checker u_swcrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
